// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file prs_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PRS_ASSERT_NOW(lbl, clk, rst_n, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define PRS_ASSERT_NEXT(lbl, clk, rst_n, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/prs_pkg.sv =====
// ----------------------------------------------------------------------------
// prs_pkg
// types, codes and constants of the power-management request sequencer
// ----------------------------------------------------------------------------
package prs_pkg;

    localparam int CMD_W    = 3;
    localparam int VAL_W    = 10;
    localparam int LIMIT_W  = 10;
    localparam int ERR_W    = 4;
    localparam int STATUS_W = 2;
    localparam int TRANS_W  = 4;
    localparam int PHASE_W  = 4;
    localparam int BUCK_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 10;

    localparam logic [LIMIT_W-1:0] LIMIT_DEFAULT = LIMIT_W'(180);
    localparam logic [ERR_W-1:0]   ERR_SAT       = ERR_W'(15);
    localparam logic [LIMIT_W-1:0] LIMIT_MIN_RST = LIMIT_W'(32);
    localparam logic [LIMIT_W-1:0] LIMIT_MAX_RST = LIMIT_W'(800);
    localparam logic [ERR_W-1:0]   ERR_LIMIT_RST = ERR_W'(3);

    // commands
    localparam logic [CMD_W-1:0] CMD_SET_LIMIT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET_CHG   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SET_BUCK  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SHIP      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MEAS_GO   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_MEAS_STOP = 3'd5;
    localparam logic [CMD_W-1:0] CMD_BUS_DONE  = 3'd6;
    localparam logic [CMD_W-1:0] CMD_TIMER     = 3'd7;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BUSY  = 2'd2;

    // transaction codes
    localparam logic [TRANS_W-1:0] TR_LIMIT    = 4'd0;
    localparam logic [TRANS_W-1:0] TR_LIMIT_EN = 4'd1;
    localparam logic [TRANS_W-1:0] TR_CHG_ON   = 4'd2;
    localparam logic [TRANS_W-1:0] TR_CHG_OFF  = 4'd3;
    localparam logic [TRANS_W-1:0] TR_BUCK     = 4'd4;
    localparam logic [TRANS_W-1:0] TR_READOUT  = 4'd7;
    localparam logic [TRANS_W-1:0] TR_TRIGGER  = 4'd8;
    localparam logic [TRANS_W-1:0] TR_SHIP     = 4'd9;

    // buck modes
    localparam logic [BUCK_W-1:0] BUCK_AUTO = 2'd0;
    localparam logic [BUCK_W-1:0] BUCK_PWM  = 2'd1;
    localparam logic [BUCK_W-1:0] BUCK_PFM  = 2'd2;

    // sequencer phases
    localparam logic [PHASE_W-1:0] PH_IDLE    = 4'd0;
    localparam logic [PHASE_W-1:0] PH_CHG_ON  = 4'd1;
    localparam logic [PHASE_W-1:0] PH_CHG_OFF = 4'd2;
    localparam logic [PHASE_W-1:0] PH_LIMIT   = 4'd3;
    localparam logic [PHASE_W-1:0] PH_BUCK    = 4'd4;
    localparam logic [PHASE_W-1:0] PH_SHIP    = 4'd5;
    localparam logic [PHASE_W-1:0] PH_TRIGGER = 4'd6;
    localparam logic [PHASE_W-1:0] PH_WAIT    = 4'd7;
    localparam logic [PHASE_W-1:0] PH_READOUT = 4'd8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ADC_WAIT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ERR_LIMIT = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [VAL_W-1:0] request_value;
        logic             bus_ok;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                issue_valid;
        logic [TRANS_W-1:0]  transaction;
        logic [7:0]          step_code_high;
        logic                step_code_low;
        logic                timer_start;
        logic                report_ready;
        logic                fatal_error;
    } res_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] limit_min;
        logic [LIMIT_W-1:0] limit_max;
        logic [ERR_W-1:0]   error_limit;
    } cfg_t;

endpackage

// ===== rtl/prs_req_if.sv =====
// ----------------------------------------------------------------------------
// prs_req_if
// request and completion event channel
// ----------------------------------------------------------------------------
interface prs_req_if;
    logic                      valid;
    logic                      ready;
    logic [prs_pkg::CMD_W-1:0] cmd;
    logic [prs_pkg::VAL_W-1:0] request_value;
    logic                      bus_ok;

    modport source (output valid, output cmd, output request_value, output bus_ok,
                    input ready);
    modport sink   (input valid, input cmd, input request_value, input bus_ok,
                    output ready);
endinterface

// ===== rtl/prs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// prs_rsp_if
// result channel
// ----------------------------------------------------------------------------
interface prs_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [prs_pkg::STATUS_W-1:0] status;
    logic                         issue_valid;
    logic [prs_pkg::TRANS_W-1:0]  transaction;
    logic [7:0]                   step_code_high;
    logic                         step_code_low;
    logic                         timer_start;
    logic                         report_ready;
    logic                         fatal_error;

    modport source (output valid, output status, output issue_valid, output transaction,
                    output step_code_high, output step_code_low, output timer_start,
                    output report_ready, output fatal_error, input ready);
    modport sink   (input valid, input status, input issue_valid, input transaction,
                    input step_code_high, input step_code_low, input timer_start,
                    input report_ready, input fatal_error, output ready);
endinterface

// ===== rtl/prs_cfg_if.sv =====
// ----------------------------------------------------------------------------
// prs_cfg_if
// configuration register write channel
// ----------------------------------------------------------------------------
interface prs_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [prs_pkg::CFG_IDX_W-1:0] index;
    logic [prs_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/prs_engine.sv =====
// ----------------------------------------------------------------------------
// prs_engine
// sequencer state and the per-event update with priority transaction pick
// ----------------------------------------------------------------------------
module prs_engine (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step_en,
    input  prs_pkg::req_t req,
    input  prs_pkg::cfg_t cfg,
    output prs_pkg::res_t res
);

    logic [prs_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [prs_pkg::LIMIT_W-1:0] limit_written_reg, limit_written_next;
    logic [prs_pkg::LIMIT_W-1:0] limit_requested_reg, limit_requested_next;
    logic [prs_pkg::LIMIT_W-1:0] limit_in_flight_reg, limit_in_flight_next;
    logic                        charging_on_reg, charging_on_next;
    logic                        charging_wanted_reg, charging_wanted_next;
    logic [prs_pkg::BUCK_W-1:0]  buck_written_reg, buck_written_next;
    logic [prs_pkg::BUCK_W-1:0]  buck_wanted_reg, buck_wanted_next;
    logic [prs_pkg::BUCK_W-1:0]  buck_in_flight_reg, buck_in_flight_next;
    logic                        ship_pending_reg, ship_pending_next;
    logic                        trigger_pending_reg, trigger_pending_next;
    logic                        readout_pending_reg, readout_pending_next;
    logic                        measure_owner_reg, measure_owner_next;
    logic [prs_pkg::ERR_W-1:0]   error_run_reg, error_run_next;

    always_comb
    begin
        logic pick;
        pick                 = 1'b0;
        res                  = '0;
        phase_next           = phase_reg;
        limit_written_next   = limit_written_reg;
        limit_requested_next = limit_requested_reg;
        limit_in_flight_next = limit_in_flight_reg;
        charging_on_next     = charging_on_reg;
        charging_wanted_next = charging_wanted_reg;
        buck_written_next    = buck_written_reg;
        buck_wanted_next     = buck_wanted_reg;
        buck_in_flight_next  = buck_in_flight_reg;
        ship_pending_next    = ship_pending_reg;
        trigger_pending_next = trigger_pending_reg;
        readout_pending_next = readout_pending_reg;
        measure_owner_next   = measure_owner_reg;
        error_run_next       = error_run_reg;

        case (req.cmd)
            prs_pkg::CMD_SET_LIMIT:
            begin
                if (!(req.request_value inside {[cfg.limit_min:cfg.limit_max]}))
                begin
                    res.status = prs_pkg::ST_RANGE;
                end
                else
                begin
                    limit_requested_next = req.request_value;
                    pick = 1'b1;
                end
            end
            prs_pkg::CMD_SET_CHG:
            begin
                charging_wanted_next = (req.request_value != '0);
                pick = 1'b1;
            end
            prs_pkg::CMD_SET_BUCK:
            begin
                if (req.request_value inside {prs_pkg::VAL_W'(prs_pkg::BUCK_PWM),
                                              prs_pkg::VAL_W'(prs_pkg::BUCK_PFM)})
                begin
                    buck_wanted_next = req.request_value[prs_pkg::BUCK_W-1:0];
                end
                else
                begin
                    buck_wanted_next = prs_pkg::BUCK_AUTO;
                end
                pick = 1'b1;
            end
            prs_pkg::CMD_SHIP:
            begin
                ship_pending_next = 1'b1;
                pick = 1'b1;
            end
            prs_pkg::CMD_MEAS_GO:
            begin
                if (measure_owner_reg)
                begin
                    res.status = prs_pkg::ST_BUSY;
                end
                else
                begin
                    measure_owner_next   = 1'b1;
                    trigger_pending_next = 1'b1;
                    pick = 1'b1;
                end
            end
            prs_pkg::CMD_MEAS_STOP:
            begin
                measure_owner_next = 1'b0;
            end
            prs_pkg::CMD_BUS_DONE:
            begin
                if (!(phase_reg inside {prs_pkg::PH_IDLE, prs_pkg::PH_WAIT}))
                begin
                    pick = 1'b1;
                    if (!req.bus_ok)
                    begin
                        if (error_run_reg < prs_pkg::ERR_SAT)
                        begin
                            error_run_next = error_run_reg + 1'b1;
                        end
                        phase_next = prs_pkg::PH_IDLE;
                    end
                    else
                    begin
                        error_run_next = '0;
                        phase_next     = prs_pkg::PH_IDLE;
                        case (phase_reg)
                            prs_pkg::PH_CHG_ON:  charging_on_next = 1'b1;
                            prs_pkg::PH_CHG_OFF: charging_on_next = 1'b0;
                            prs_pkg::PH_LIMIT:   limit_written_next = limit_in_flight_reg;
                            prs_pkg::PH_BUCK:    buck_written_next = buck_in_flight_reg;
                            prs_pkg::PH_SHIP:    ship_pending_next = 1'b0;
                            prs_pkg::PH_TRIGGER:
                            begin
                                trigger_pending_next = 1'b0;
                                res.timer_start      = 1'b1;
                                phase_next           = prs_pkg::PH_WAIT;
                            end
                            prs_pkg::PH_READOUT:
                            begin
                                readout_pending_next = 1'b0;
                                res.report_ready     = measure_owner_reg;
                                measure_owner_next   = 1'b0;
                            end
                            default: phase_next = prs_pkg::PH_IDLE;
                        endcase
                    end
                end
            end
            default:
            begin
                if (phase_reg == prs_pkg::PH_WAIT)
                begin
                    readout_pending_next = 1'b1;
                    phase_next           = prs_pkg::PH_IDLE;
                    pick = 1'b1;
                end
            end
        endcase

        // priority pick when nothing is outstanding
        if (pick && phase_next == prs_pkg::PH_IDLE)
        begin
            if (limit_written_next != limit_requested_next)
            begin
                limit_in_flight_next = limit_requested_next;
                res.issue_valid      = 1'b1;
                res.transaction      = charging_on_next ? prs_pkg::TR_LIMIT_EN
                                                        : prs_pkg::TR_LIMIT;
                res.step_code_high   = limit_requested_next[prs_pkg::LIMIT_W-1:2];
                res.step_code_low    = limit_requested_next[1];
                phase_next           = prs_pkg::PH_LIMIT;
            end
            else if (charging_on_next != charging_wanted_next)
            begin
                res.issue_valid = 1'b1;
                res.transaction = charging_wanted_next ? prs_pkg::TR_CHG_ON
                                                       : prs_pkg::TR_CHG_OFF;
                phase_next      = charging_wanted_next ? prs_pkg::PH_CHG_ON
                                                       : prs_pkg::PH_CHG_OFF;
            end
            else if (buck_written_next != buck_wanted_next)
            begin
                buck_in_flight_next = buck_wanted_next;
                res.issue_valid     = 1'b1;
                res.transaction     = prs_pkg::TR_BUCK
                                      + prs_pkg::TRANS_W'(buck_wanted_next);
                phase_next          = prs_pkg::PH_BUCK;
            end
            else if (readout_pending_next)
            begin
                res.issue_valid = 1'b1;
                res.transaction = prs_pkg::TR_READOUT;
                phase_next      = prs_pkg::PH_READOUT;
            end
            else if (trigger_pending_next)
            begin
                res.issue_valid = 1'b1;
                res.transaction = prs_pkg::TR_TRIGGER;
                phase_next      = prs_pkg::PH_TRIGGER;
            end
            else if (ship_pending_next)
            begin
                res.issue_valid = 1'b1;
                res.transaction = prs_pkg::TR_SHIP;
                phase_next      = prs_pkg::PH_SHIP;
            end
        end

        res.fatal_error = (error_run_next > cfg.error_limit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= prs_pkg::PH_IDLE;
            limit_written_reg   <= prs_pkg::LIMIT_DEFAULT;
            limit_requested_reg <= prs_pkg::LIMIT_DEFAULT;
            limit_in_flight_reg <= prs_pkg::LIMIT_DEFAULT;
            charging_on_reg     <= 1'b0;
            charging_wanted_reg <= 1'b0;
            buck_written_reg    <= prs_pkg::BUCK_AUTO;
            buck_wanted_reg     <= prs_pkg::BUCK_AUTO;
            buck_in_flight_reg  <= prs_pkg::BUCK_AUTO;
            ship_pending_reg    <= 1'b0;
            trigger_pending_reg <= 1'b0;
            readout_pending_reg <= 1'b0;
            measure_owner_reg   <= 1'b0;
            error_run_reg       <= '0;
        end
        else if (step_en)
        begin
            phase_reg           <= phase_next;
            limit_written_reg   <= limit_written_next;
            limit_requested_reg <= limit_requested_next;
            limit_in_flight_reg <= limit_in_flight_next;
            charging_on_reg     <= charging_on_next;
            charging_wanted_reg <= charging_wanted_next;
            buck_written_reg    <= buck_written_next;
            buck_wanted_reg     <= buck_wanted_next;
            buck_in_flight_reg  <= buck_in_flight_next;
            ship_pending_reg    <= ship_pending_next;
            trigger_pending_reg <= trigger_pending_next;
            readout_pending_reg <= readout_pending_next;
            measure_owner_reg   <= measure_owner_next;
            error_run_reg       <= error_run_next;
        end
    end

endmodule

// ===== rtl/pmic_request_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// pmic_request_sequencer_top
// power-management request sequencer: tracks requested and written settings
// and issues one prioritized bus transaction code per event when idle
// ----------------------------------------------------------------------------
//  channel   dir   handshake         payload
//  req_in    in    valid / ready     cmd, request_value, bus_ok
//  rsp_out   out   valid / ready     status .. fatal_error, one item per event
//  cfg       in    valid / ready     index, data (ready always high)
//
//  one event per cycle while rsp_out is ready; path: event register, result register
//  the event register feeds the state update, the result register holds the item
//  a stalled result holds; req_in stays ready while the event register can drain
//  reset clears all control state and loads the register reset values
//  the adc wait time is run by the external timer and has no effect here
// ----------------------------------------------------------------------------
module pmic_request_sequencer_top (
    input logic         clk,
    input logic         rst_n,
    prs_req_if.sink     req_in,
    prs_rsp_if.source   rsp_out,
    prs_cfg_if.sink     cfg
);

    logic                        in_valid_reg, in_valid_next;
    prs_pkg::req_t               req_reg;
    logic                        out_valid_reg, out_valid_next;
    prs_pkg::res_t               res_reg;
    prs_pkg::res_t               res_step;
    prs_pkg::cfg_t               cfg_reg;
    logic                        in_take;
    logic                        advance;

    assign advance       = in_valid_reg && (!out_valid_reg || rsp_out.ready);
    assign req_in.ready  = !in_valid_reg || advance;
    assign in_take       = req_in.valid && req_in.ready;
    assign in_valid_next = in_take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !rsp_out.ready);
    assign cfg.ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_reg.cmd           <= req_in.cmd;
            req_reg.request_value <= req_in.request_value;
            req_reg.bus_ok        <= req_in.bus_ok;
        end
        if (advance)
        begin
            res_reg <= res_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.limit_min   <= prs_pkg::LIMIT_MIN_RST;
            cfg_reg.limit_max   <= prs_pkg::LIMIT_MAX_RST;
            cfg_reg.error_limit <= prs_pkg::ERR_LIMIT_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                prs_pkg::CFG_LIMIT_MIN: cfg_reg.limit_min <= cfg.data;
                prs_pkg::CFG_LIMIT_MAX: cfg_reg.limit_max <= cfg.data;
                prs_pkg::CFG_ERR_LIMIT:
                    cfg_reg.error_limit <= cfg.data[prs_pkg::ERR_W-1:0];
                default: ;
            endcase
        end
    end

    prs_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .req     (req_reg),
        .cfg     (cfg_reg),
        .res     (res_step)
    );

    assign rsp_out.valid          = out_valid_reg;
    assign rsp_out.status         = res_reg.status;
    assign rsp_out.issue_valid    = res_reg.issue_valid;
    assign rsp_out.transaction    = res_reg.transaction;
    assign rsp_out.step_code_high = res_reg.step_code_high;
    assign rsp_out.step_code_low  = res_reg.step_code_low;
    assign rsp_out.timer_start    = res_reg.timer_start;
    assign rsp_out.report_ready   = res_reg.report_ready;
    assign rsp_out.fatal_error    = res_reg.fatal_error;

endmodule

// ===== rtl/prs_checker.sv =====
// ----------------------------------------------------------------------------
// prs_checker
// port-level checks on the result channel of the sequencer
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module prs_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [prs_pkg::STATUS_W-1:0] status,
    input logic                         issue_valid,
    input logic [prs_pkg::TRANS_W-1:0]  transaction,
    input logic [7:0]                   step_code_high,
    input logic                         step_code_low,
    input logic                         timer_start,
    input logic                         report_ready
);

    `PRS_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(transaction) && $stable(status))
    `PRS_ASSERT_NOW(a_no_issue_zero, clk, rst_n, out_valid && !issue_valid,
        transaction == prs_pkg::TR_LIMIT && step_code_high == 8'd0 && !step_code_low)
    `PRS_ASSERT_NOW(a_reject_quiet, clk, rst_n, out_valid && status != prs_pkg::ST_OK,
        !issue_valid && !timer_start && !report_ready)
    `PRS_ASSERT_NOW(a_step_only_limit, clk, rst_n,
        out_valid && (step_code_high != 8'd0 || step_code_low),
        issue_valid && (transaction == prs_pkg::TR_LIMIT ||
                        transaction == prs_pkg::TR_LIMIT_EN))
    `PRS_ASSERT_NOW(a_one_completion, clk, rst_n, out_valid,
        !(timer_start && report_ready))

endmodule

bind pmic_request_sequencer_top prs_checker u_prs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (rsp_out.valid),
    .out_ready      (rsp_out.ready),
    .status         (rsp_out.status),
    .issue_valid    (rsp_out.issue_valid),
    .transaction    (rsp_out.transaction),
    .step_code_high (rsp_out.step_code_high),
    .step_code_low  (rsp_out.step_code_low),
    .timer_start    (rsp_out.timer_start),
    .report_ready   (rsp_out.report_ready)
);
